// ===== rtl/mecanum_drive_command_mixer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Mecanum mixer assertion macros
// Shared concurrent check forms, sampled on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef MECANUM_DRIVE_COMMAND_MIXER_UNIT_ASSERT_SVH
`define MECANUM_DRIVE_COMMAND_MIXER_UNIT_ASSERT_SVH

// Same-cycle implication check
`define MDCM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check
`define MDCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer package
// Shared codes, limits, pipeline word types and the discrete motion table.
// ----------------------------------------------------------------------------
package mdcm_pkg;

    // Limits
    localparam int CMD_LIMIT   = 1000;
    localparam int DEAD_BAND   = 35;
    localparam int PWM_LIMIT   = 255;
    localparam logic [7:0] SPEED_RESET = 8'd180;

    // Reciprocal of 1000 for products up to 255000, exact after truncation
    localparam int RECIP_SHIFT = 28;
    localparam logic [18:0] RECIP_1000 = 19'd268436;

    // Quotient bits of the normalizing divider
    localparam int DIV_STEPS = 10;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPEED  = 2'd0;
    localparam logic [1:0] CFG_LAYOUT = 2'd1;
    localparam logic [1:0] CFG_INVERT = 2'd2;

    // Request types
    localparam logic REQ_TWIST = 1'b0;

    // Bridge direction codes
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Drive modes
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_DISC = 2'd1;
    localparam logic [1:0] MODE_VEL  = 2'd2;

    // Block reasons
    localparam logic [2:0] RSN_NONE  = 3'd0;
    localparam logic [2:0] RSN_ESTOP = 3'd1;
    localparam logic [2:0] RSN_BOTH  = 3'd2;
    localparam logic [2:0] RSN_FRONT = 3'd3;
    localparam logic [2:0] RSN_BACK  = 3'd4;

    // Motion codes
    localparam logic [3:0] MC_STOP    = 4'd0;
    localparam logic [3:0] MC_FWD     = 4'd1;
    localparam logic [3:0] MC_BACK    = 4'd2;
    localparam logic [3:0] MC_STR_L   = 4'd3;
    localparam logic [3:0] MC_STR_R   = 4'd4;
    localparam logic [3:0] MC_ROT_L   = 4'd5;
    localparam logic [3:0] MC_ROT_R   = 4'd6;
    localparam logic [3:0] MC_FWD_L   = 4'd7;
    localparam logic [3:0] MC_FWD_R   = 4'd8;
    localparam logic [3:0] MC_BACK_L  = 4'd9;
    localparam logic [3:0] MC_BACK_R  = 4'd10;

    // Shaped twist component, range +-1000
    typedef logic signed [10:0] t_cmd;

    // Per-word control carried along the pipe
    typedef struct packed {
        logic             twist;
        logic             norm;
        logic [1:0]       mode;
        logic [2:0]       reason;
        logic [3:0][1:0]  ddir;
    } t_meta;

    // One wheel lane: sign, magnitude, divider remainder and quotient
    typedef struct packed {
        logic        neg;
        logic [11:0] mag;
        logic [21:0] rem;
        logic [9:0]  quo;
    } t_lane;

    typedef struct packed {
        t_meta             meta;
        logic [11:0]       peak;
        t_lane [3:0]       lane;
    } t_work;

    // Wheel directions for a motion code, index 0 FL, 1 FR, 2 BL, 3 BR
    function automatic logic [3:0][1:0] motion_dirs(input logic opp, input logic [3:0] m);
        logic [3:0][1:0] d;
        d = {DIR_OFF, DIR_OFF, DIR_OFF, DIR_OFF};
        if (!opp) begin
            unique case (m)
                MC_FWD:    d = {DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD};
                MC_BACK:   d = {DIR_REV, DIR_REV, DIR_REV, DIR_REV};
                MC_STR_L:  d = {DIR_REV, DIR_FWD, DIR_FWD, DIR_REV};
                MC_STR_R:  d = {DIR_FWD, DIR_REV, DIR_REV, DIR_FWD};
                MC_ROT_L:  d = {DIR_FWD, DIR_REV, DIR_FWD, DIR_REV};
                MC_ROT_R:  d = {DIR_REV, DIR_FWD, DIR_REV, DIR_FWD};
                MC_FWD_L:  d = {DIR_OFF, DIR_FWD, DIR_FWD, DIR_OFF};
                MC_FWD_R:  d = {DIR_FWD, DIR_OFF, DIR_OFF, DIR_FWD};
                MC_BACK_L: d = {DIR_REV, DIR_OFF, DIR_OFF, DIR_REV};
                MC_BACK_R: d = {DIR_OFF, DIR_REV, DIR_REV, DIR_OFF};
                default:   d = {DIR_OFF, DIR_OFF, DIR_OFF, DIR_OFF};
            endcase
        end else begin
            unique case (m)
                MC_FWD:    d = {DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD};
                MC_BACK:   d = {DIR_REV, DIR_REV, DIR_REV, DIR_REV};
                MC_STR_L:  d = {DIR_REV, DIR_FWD, DIR_REV, DIR_FWD};
                MC_STR_R:  d = {DIR_FWD, DIR_REV, DIR_FWD, DIR_REV};
                MC_ROT_L:  d = {DIR_FWD, DIR_REV, DIR_FWD, DIR_REV};
                MC_ROT_R:  d = {DIR_REV, DIR_FWD, DIR_REV, DIR_FWD};
                MC_FWD_L:  d = {DIR_OFF, DIR_FWD, DIR_OFF, DIR_FWD};
                MC_FWD_R:  d = {DIR_FWD, DIR_OFF, DIR_FWD, DIR_OFF};
                MC_BACK_L: d = {DIR_OFF, DIR_REV, DIR_OFF, DIR_REV};
                MC_BACK_R: d = {DIR_REV, DIR_OFF, DIR_REV, DIR_OFF};
                default:   d = {DIR_OFF, DIR_OFF, DIR_OFF, DIR_OFF};
            endcase
        end
        return d;
    endfunction

endpackage

// ===== rtl/mecanum_drive_command_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// Mecanum drive command mixer
// Turns twist or discrete motion commands into four wheel bridge commands.
// ----------------------------------------------------------------------------
// The block takes one command word per cycle unless the output is stalled, and
// returns one wheel word per command, in order. The wheel word passes sixteen
// register stages: three front stages (shape, safety and mix, peak), ten
// divider stages that normalize by the peak one quotient bit at a time, and
// three stages that scale by motor speed and form the outputs. The whole pipe
// advances together; it holds when the output word is valid and not taken.
// Configuration writes land at once and must be made with no command in
// flight.
module mecanum_drive_command_mixer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic signed [15:0]   i_fwd_cmd,
    input  logic signed [15:0]   i_left_cmd,
    input  logic signed [15:0]   i_turn_cmd,
    input  logic [3:0]           i_motion_code,
    input  logic                 i_front_cliff,
    input  logic                 i_back_cliff,
    input  logic                 i_estop_latched,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_fl_dir,
    output logic [7:0]           o_fl_pwm,
    output logic [1:0]           o_fr_dir,
    output logic [7:0]           o_fr_pwm,
    output logic [1:0]           o_bl_dir,
    output logic [7:0]           o_bl_pwm,
    output logic [1:0]           o_br_dir,
    output logic [7:0]           o_br_pwm,
    output logic [1:0]           o_drive_mode,
    output logic [2:0]           o_block_reason
);
    import mdcm_pkg::*;
    `include "mecanum_drive_command_mixer_unit_assert.svh"

    // Configuration registers
    logic [7:0] r_motor_speed;
    logic       r_opposite_layout;
    logic [3:0] r_invert_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_speed     <= SPEED_RESET;
            r_opposite_layout <= 1'b0;
            r_invert_mask     <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED:  r_motor_speed     <= i_cfg_data;
                CFG_LAYOUT: r_opposite_layout <= i_cfg_data[0];
                CFG_INVERT: r_invert_mask     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Advance the pipe unless the output word is stalled
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic  fr_v, dv_v;
    t_work fr_w, dv_w;

    mdcm_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (i_in_valid),
        .i_req_type        (i_req_type),
        .i_fwd_cmd         (i_fwd_cmd),
        .i_left_cmd        (i_left_cmd),
        .i_turn_cmd        (i_turn_cmd),
        .i_motion_code     (i_motion_code),
        .i_front_cliff     (i_front_cliff),
        .i_back_cliff      (i_back_cliff),
        .i_estop_latched   (i_estop_latched),
        .i_opposite_layout (r_opposite_layout),
        .i_invert_mask     (r_invert_mask),
        .o_valid           (fr_v),
        .o_work            (fr_w)
    );

    mdcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_v),
        .i_work  (fr_w),
        .o_valid (dv_v),
        .o_work  (dv_w)
    );

    mdcm_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (dv_v),
        .i_work         (dv_w),
        .i_motor_speed  (r_motor_speed),
        .i_invert_mask  (r_invert_mask),
        .o_valid        (o_out_valid),
        .o_fl_dir       (o_fl_dir),
        .o_fl_pwm       (o_fl_pwm),
        .o_fr_dir       (o_fr_dir),
        .o_fr_pwm       (o_fr_pwm),
        .o_bl_dir       (o_bl_dir),
        .o_bl_pwm       (o_bl_pwm),
        .o_br_dir       (o_br_dir),
        .o_br_pwm       (o_br_pwm),
        .o_drive_mode   (o_drive_mode),
        .o_block_reason (o_block_reason)
    );

    // A stopped word drives no wheel
    `MDCM_ASSERT_IMPLY(a_stop_idle, o_out_valid && o_drive_mode == MODE_STOP, o_fl_pwm == 8'd0 && o_fr_pwm == 8'd0 && o_bl_pwm == 8'd0 && o_br_pwm == 8'd0, "stop word with duty")
    // A blocked command always reports stopped
    `MDCM_ASSERT_IMPLY(a_block_stop, o_out_valid && o_block_reason != RSN_NONE, o_drive_mode == MODE_STOP, "blocked word not stopped")
    // An idle front-left bridge has no duty
    `MDCM_ASSERT_IMPLY(a_off_zero, o_out_valid && o_fl_dir == DIR_OFF, o_fl_pwm == 8'd0, "idle bridge with duty")
    // A stalled output word stays valid
    `MDCM_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready, o_out_valid, "output word lost")

endmodule

// ===== rtl/mdcm_front.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer front end
// Shapes the twist, applies the safety checks, mixes wheels and finds the peak.
// ----------------------------------------------------------------------------
module mdcm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_req_type,
    input  logic signed [15:0]   i_fwd_cmd,
    input  logic signed [15:0]   i_left_cmd,
    input  logic signed [15:0]   i_turn_cmd,
    input  logic [3:0]           i_motion_code,
    input  logic                 i_front_cliff,
    input  logic                 i_back_cliff,
    input  logic                 i_estop_latched,
    input  logic                 i_opposite_layout,
    input  logic [3:0]           i_invert_mask,
    output logic                 o_valid,
    output mdcm_pkg::t_work      o_work
);
    import mdcm_pkg::*;

    // Clamp to +-1000 and zero the deadband
    function automatic t_cmd shape(input logic signed [15:0] v);
        t_cmd r;
        if (v > 16'sd1000)
            r = 11'sd1000;
        else if (v < -16'sd1000)
            r = -11'sd1000;
        else if (v > -16'sd35 && v < 16'sd35)
            r = '0;
        else
            r = v[10:0];
        return r;
    endfunction

    // Stage 1: shaped command
    logic       r_s1_v;
    logic       r_s1_type;
    t_cmd       r_s1_f, r_s1_l, r_s1_c;
    logic [3:0] r_s1_m;
    logic       r_s1_fc, r_s1_bc, r_s1_es;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_type <= i_req_type;
            r_s1_f    <= shape(i_fwd_cmd);
            r_s1_l    <= shape(i_left_cmd);
            r_s1_c    <= shape(i_turn_cmd);
            r_s1_m    <= i_motion_code;
            r_s1_fc   <= i_front_cliff;
            r_s1_bc   <= i_back_cliff;
            r_s1_es   <= i_estop_latched;
        end
    end

    // Stage 2: safety decision and wheel mix
    t_meta                     n_meta;
    logic signed [3:0][12:0]   n_w;
    logic signed [12:0]        f13, l13, c13;
    logic [3:0][1:0]           tab;
    logic                      back_move, fwd_move;

    always_comb begin
        f13 = 13'(r_s1_f);
        l13 = 13'(r_s1_l);
        c13 = 13'(r_s1_c);
        if (!i_opposite_layout) begin
            n_w[0] = f13 - l13 - c13;
            n_w[1] = f13 + l13 + c13;
            n_w[2] = f13 + l13 - c13;
            n_w[3] = f13 - l13 + c13;
        end else begin
            n_w[0] = f13 + l13 - c13;
            n_w[1] = f13 - l13 + c13;
            n_w[2] = f13 + l13 - c13;
            n_w[3] = f13 - l13 + c13;
        end

        back_move = (r_s1_m == MC_BACK) || (r_s1_m == MC_BACK_L) || (r_s1_m == MC_BACK_R);
        fwd_move  = (r_s1_m == MC_FWD) || (r_s1_m == MC_FWD_L) || (r_s1_m == MC_FWD_R);
        tab = motion_dirs(i_opposite_layout, r_s1_m);

        n_meta = '0;
        n_meta.mode   = MODE_STOP;
        n_meta.reason = RSN_NONE;
        if (r_s1_type == REQ_TWIST) begin
            priority if (r_s1_es) begin
                n_meta.reason = RSN_ESTOP;
            end else if (r_s1_f == 0 && r_s1_l == 0 && r_s1_c == 0) begin
                n_meta.reason = RSN_NONE;
            end else if (r_s1_fc && r_s1_bc) begin
                n_meta.reason = RSN_BOTH;
            end else if (r_s1_fc && (r_s1_f >= 0 || r_s1_l != 0 || r_s1_c != 0)) begin
                n_meta.reason = RSN_FRONT;
            end else if (r_s1_bc && (r_s1_f <= 0 || r_s1_l != 0 || r_s1_c != 0)) begin
                n_meta.reason = RSN_BACK;
            end else begin
                n_meta.twist = 1'b1;
                n_meta.mode  = MODE_VEL;
            end
        end else begin
            priority if (r_s1_m != MC_STOP && r_s1_es) begin
                n_meta.reason = RSN_ESTOP;
            end else if (r_s1_m != MC_STOP && r_s1_fc && r_s1_bc) begin
                n_meta.reason = RSN_BOTH;
            end else if (r_s1_m != MC_STOP && r_s1_fc && !back_move) begin
                n_meta.reason = RSN_FRONT;
            end else if (r_s1_m != MC_STOP && r_s1_bc && !fwd_move) begin
                n_meta.reason = RSN_BACK;
            end else if (r_s1_m > MC_BACK_R || r_s1_m == MC_STOP) begin
                n_meta.mode = MODE_STOP;
            end else begin
                n_meta.mode = MODE_DISC;
                for (int i = 0; i < 4; i++) begin
                    if (i_invert_mask[i] && tab[i] == DIR_FWD)
                        n_meta.ddir[i] = DIR_REV;
                    else if (i_invert_mask[i] && tab[i] == DIR_REV)
                        n_meta.ddir[i] = DIR_FWD;
                    else
                        n_meta.ddir[i] = tab[i];
                end
            end
        end
    end

    logic               r_s2_v;
    t_meta              r_s2_meta;
    logic [3:0]         r_s2_neg;
    logic [3:0][11:0]   r_s2_mag;
    logic [3:0][12:0]   n_abs;

    always_comb begin
        for (int i = 0; i < 4; i++)
            n_abs[i] = n_w[i][12] ? 13'(-n_w[i]) : 13'(n_w[i]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (i_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_meta <= n_meta;
            for (int i = 0; i < 4; i++) begin
                r_s2_neg[i] <= n_w[i][12];
                r_s2_mag[i] <= n_abs[i][11:0];
            end
        end
    end

    // Stage 3: peak magnitude and scaled dividend
    logic [11:0] pk01, pk23, n_peak;
    t_work       n_work;

    always_comb begin
        pk01   = (r_s2_mag[0] > r_s2_mag[1]) ? r_s2_mag[0] : r_s2_mag[1];
        pk23   = (r_s2_mag[2] > r_s2_mag[3]) ? r_s2_mag[2] : r_s2_mag[3];
        n_peak = (pk01 > pk23) ? pk01 : pk23;
        n_work = '0;
        n_work.meta      = r_s2_meta;
        n_work.meta.norm = (n_peak > 12'(CMD_LIMIT));
        n_work.peak      = n_peak;
        for (int i = 0; i < 4; i++) begin
            n_work.lane[i].neg = r_s2_neg[i];
            n_work.lane[i].mag = r_s2_mag[i];
            // times 1000 = 1024 - 16 - 8
            n_work.lane[i].rem = ({10'd0, r_s2_mag[i]} << 10) - ({10'd0, r_s2_mag[i]} << 4)
                               - ({10'd0, r_s2_mag[i]} << 3);
            n_work.lane[i].quo = '0;
        end
    end

    logic  r_s3_v;
    t_work r_s3_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (i_en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_work <= n_work;
        end
    end

    assign o_valid = r_s3_v;
    assign o_work  = r_s3_work;

endmodule

// ===== rtl/mdcm_div.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer normalizing divider
// Restoring division of |w|*1000 by the peak, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mdcm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  mdcm_pkg::t_work      i_work,
    output logic                 o_valid,
    output mdcm_pkg::t_work      o_work
);
    import mdcm_pkg::*;

    logic  r_v [DIV_STEPS];
    t_work r_w [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - k;
        logic  src_v;
        t_work src_w;
        t_work n_w;
        logic [21:0] dvs;

        if (k == 0) begin : g_first
            assign src_v = i_valid;
            assign src_w = i_work;
        end else begin : g_next
            assign src_v = r_v[k-1];
            assign src_w = r_w[k-1];
        end

        // Try subtracting the shifted peak in every lane
        always_comb begin
            n_w = src_w;
            dvs = {10'd0, src_w.peak} << BIT;
            for (int i = 0; i < 4; i++) begin
                if (src_w.lane[i].rem >= dvs) begin
                    n_w.lane[i].rem      = src_w.lane[i].rem - dvs;
                    n_w.lane[i].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[k] <= n_w;
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_work  = r_w[DIV_STEPS-1];

endmodule

// ===== rtl/mdcm_scale.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer speed scaling and output stage
// Scales by motor speed, divides by 1000 and forms direction and duty.
// ----------------------------------------------------------------------------
module mdcm_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  mdcm_pkg::t_work      i_work,
    input  logic [7:0]           i_motor_speed,
    input  logic [3:0]           i_invert_mask,
    output logic                 o_valid,
    output logic [1:0]           o_fl_dir,
    output logic [7:0]           o_fl_pwm,
    output logic [1:0]           o_fr_dir,
    output logic [7:0]           o_fr_pwm,
    output logic [1:0]           o_bl_dir,
    output logic [7:0]           o_bl_pwm,
    output logic [1:0]           o_br_dir,
    output logic [7:0]           o_br_pwm,
    output logic [1:0]           o_drive_mode,
    output logic [2:0]           o_block_reason
);
    import mdcm_pkg::*;

    // Stage A: pick normalized or raw magnitude, multiply by speed
    logic             r_a_v;
    t_meta            r_a_meta;
    logic [3:0]       r_a_neg;
    logic [3:0][17:0] r_a_p;
    logic [3:0][9:0]  n_mag;

    always_comb begin
        for (int i = 0; i < 4; i++)
            n_mag[i] = i_work.meta.norm ? i_work.lane[i].quo : i_work.lane[i].mag[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_meta <= i_work.meta;
            for (int i = 0; i < 4; i++) begin
                r_a_neg[i] <= i_work.lane[i].neg;
                r_a_p[i]   <= 18'(n_mag[i]) * 18'(i_motor_speed);
            end
        end
    end

    // Stage B: divide by 1000 through the reciprocal
    logic             r_b_v;
    t_meta            r_b_meta;
    logic [3:0]       r_b_neg;
    logic [3:0][8:0]  r_b_q;
    logic [3:0][36:0] n_prod;

    always_comb begin
        for (int i = 0; i < 4; i++)
            n_prod[i] = 37'(r_a_p[i]) * 37'(RECIP_1000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_meta <= r_a_meta;
            r_b_neg  <= r_a_neg;
            for (int i = 0; i < 4; i++)
                r_b_q[i] <= n_prod[i][RECIP_SHIFT+8:RECIP_SHIFT];
        end
    end

    // Stage C: clamp, invert and form bridge codes
    logic [3:0][1:0] n_dir;
    logic [3:0][7:0] n_pwm;
    logic [7:0]      duty;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            duty = (r_b_q[i] > 9'(PWM_LIMIT)) ? 8'(PWM_LIMIT) : r_b_q[i][7:0];
            if (r_b_meta.twist) begin
                if (duty == 8'd0) begin
                    n_dir[i] = DIR_OFF;
                    n_pwm[i] = 8'd0;
                end else begin
                    n_dir[i] = (r_b_neg[i] ^ i_invert_mask[i]) ? DIR_REV : DIR_FWD;
                    n_pwm[i] = duty;
                end
            end else begin
                n_dir[i] = r_b_meta.ddir[i];
                n_pwm[i] = (r_b_meta.ddir[i] != DIR_OFF) ? i_motor_speed : 8'd0;
            end
        end
    end

    logic r_c_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_fl_dir       <= n_dir[0];
            o_fl_pwm       <= n_pwm[0];
            o_fr_dir       <= n_dir[1];
            o_fr_pwm       <= n_pwm[1];
            o_bl_dir       <= n_dir[2];
            o_bl_pwm       <= n_pwm[2];
            o_br_dir       <= n_dir[3];
            o_br_pwm       <= n_pwm[3];
            o_drive_mode   <= r_b_meta.mode;
            o_block_reason <= r_b_meta.reason;
        end
    end

    assign o_valid = r_c_v;

endmodule

// ===== sim/tb_mecanum_drive_command_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// Mecanum drive command mixer testbench
// Drives twist and discrete motion commands through the mixer under several
// register settings and flow-control patterns. Every wheel word is checked
// field by field against an in-bench mixing model or a typed row's stop word.
// ----------------------------------------------------------------------------
module tb_mecanum_drive_command_mixer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mdcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASE_WORDS    = 300;

    // Wheel word as seen at the output, index 0 FL, 1 FR, 2 BL, 3 BR
    typedef struct packed {
        logic [3:0][1:0] dir;
        logic [3:0][7:0] pwm;
        logic [1:0]      mode;
        logic [2:0]      reason;
    } t_wheel_word;

    // One directed command; typed rows carry a known stop reason
    typedef struct {
        logic        req;
        int          f;
        int          l;
        int          c;
        logic [3:0]  m;
        logic        fc;
        logic        bc;
        logic        es;
        logic        typed;
        logic [2:0]  reason;
    } t_cmd_row;

    // Roller sign per motion code, FL FR BL BR
    localparam int X_SIGNS [11][4] = '{
        '{0, 0, 0, 0}, '{1, 1, 1, 1}, '{-1, -1, -1, -1},
        '{-1, 1, 1, -1}, '{1, -1, -1, 1}, '{-1, 1, -1, 1},
        '{1, -1, 1, -1}, '{0, 1, 1, 0}, '{1, 0, 0, 1},
        '{-1, 0, 0, -1}, '{0, -1, -1, 0}
    };
    localparam int OPP_SIGNS [11][4] = '{
        '{0, 0, 0, 0}, '{1, 1, 1, 1}, '{-1, -1, -1, -1},
        '{1, -1, 1, -1}, '{-1, 1, -1, 1}, '{-1, 1, -1, 1},
        '{1, -1, 1, -1}, '{1, 0, 1, 0}, '{0, 1, 0, 1},
        '{-1, 0, -1, 0}, '{0, -1, 0, -1}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_SPEED;
    logic [7:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_req_type = REQ_TWIST;
    logic signed [15:0] i_fwd_cmd = '0;
    logic signed [15:0] i_left_cmd = '0;
    logic signed [15:0] i_turn_cmd = '0;
    logic [3:0]         i_motion_code = MC_STOP;
    logic               i_front_cliff = 1'b0;
    logic               i_back_cliff = 1'b0;
    logic               i_estop_latched = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_fl_dir, o_fr_dir, o_bl_dir, o_br_dir;
    logic [7:0]         o_fl_pwm, o_fr_pwm, o_bl_pwm, o_br_pwm;
    logic [1:0]         o_drive_mode;
    logic [2:0]         o_block_reason;

    // Bench copy of the registers
    logic [7:0]  speed_reg = SPEED_RESET;
    logic        opp_reg = 1'b0;
    logic [3:0]  invert_reg = '0;

    // Known result riding alongside the current command
    logic        row_typed = 1'b0;
    logic [2:0]  row_reason = RSN_NONE;

    t_wheel_word wheel_words_due [$];
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          err_count = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          blocked_out = 0;
    int          idle_cycles = 0;

    mecanum_drive_command_mixer_unit u_dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic int shape_cmd(input logic signed [15:0] raw);
        int v;
        v = raw;
        if (v > CMD_LIMIT) v = CMD_LIMIT;
        if (v < -CMD_LIMIT) v = -CMD_LIMIT;
        if (v > -DEAD_BAND && v < DEAD_BAND) v = 0;
        return v;
    endfunction

    function automatic t_wheel_word stop_word(input logic [2:0] why);
        t_wheel_word w;
        w = '0;
        w.mode = MODE_STOP;
        w.reason = why;
        return w;
    endfunction

    // Compute the wheel word for one command under the current registers
    function automatic t_wheel_word mix_command(
        input logic req, input logic signed [15:0] fr, input logic signed [15:0] lr,
        input logic signed [15:0] cr, input logic [3:0] m,
        input logic fc, input logic bc, input logic es);
        t_wheel_word w;
        int f, l, c, peak, v, duty;
        int wv [4];
        logic back_move, fwd_move;
        w = '0;
        if (req == REQ_TWIST) begin
            f = shape_cmd(fr);
            l = shape_cmd(lr);
            c = shape_cmd(cr);
            if (es) return stop_word(RSN_ESTOP);
            if (f == 0 && l == 0 && c == 0) return stop_word(RSN_NONE);
            if (fc && bc) return stop_word(RSN_BOTH);
            if (fc && (f >= 0 || l != 0 || c != 0)) return stop_word(RSN_FRONT);
            if (bc && (f <= 0 || l != 0 || c != 0)) return stop_word(RSN_BACK);
            if (!opp_reg) begin
                wv[0] = f - l - c; wv[1] = f + l + c;
                wv[2] = f + l - c; wv[3] = f - l + c;
            end else begin
                wv[0] = f + l - c; wv[1] = f - l + c;
                wv[2] = f + l - c; wv[3] = f - l + c;
            end
            peak = 0;
            foreach (wv[i]) if ((wv[i] < 0 ? -wv[i] : wv[i]) > peak)
                peak = wv[i] < 0 ? -wv[i] : wv[i];
            for (int i = 0; i < 4; i++) begin
                v = wv[i];
                if (peak > CMD_LIMIT) v = v * CMD_LIMIT / peak;
                v = v * int'(speed_reg) / CMD_LIMIT;
                if (v > PWM_LIMIT) v = PWM_LIMIT;
                if (v < -PWM_LIMIT) v = -PWM_LIMIT;
                if (invert_reg[i]) v = -v;
                w.dir[i] = v > 0 ? DIR_FWD : (v < 0 ? DIR_REV : DIR_OFF);
                w.pwm[i] = 8'(v < 0 ? -v : v);
            end
            w.mode = MODE_VEL;
            w.reason = RSN_NONE;
        end else begin
            if (m != MC_STOP) begin
                back_move = (m == MC_BACK || m == MC_BACK_L || m == MC_BACK_R);
                fwd_move = (m == MC_FWD || m == MC_FWD_L || m == MC_FWD_R);
                if (es) return stop_word(RSN_ESTOP);
                if (fc && bc) return stop_word(RSN_BOTH);
                if (fc && !back_move) return stop_word(RSN_FRONT);
                if (bc && !fwd_move) return stop_word(RSN_BACK);
            end
            if (m > MC_BACK_R) return stop_word(RSN_NONE);
            for (int i = 0; i < 4; i++) begin
                duty = opp_reg ? OPP_SIGNS[m][i] : X_SIGNS[m][i];
                if (invert_reg[i]) duty = -duty;
                w.dir[i] = duty > 0 ? DIR_FWD : (duty < 0 ? DIR_REV : DIR_OFF);
                w.pwm[i] = duty != 0 ? speed_reg : 8'd0;
            end
            w.mode = (m == MC_STOP) ? MODE_STOP : MODE_DISC;
            w.reason = RSN_NONE;
        end
        return w;
    endfunction

    // Record accepted commands and check returned wheel words
    always @(posedge i_clk) begin
        t_wheel_word got, want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            words_in++;
            if (row_typed)
                wheel_words_due.push_back(stop_word(row_reason));
            else
                wheel_words_due.push_back(mix_command(i_req_type, i_fwd_cmd,
                    i_left_cmd, i_turn_cmd, i_motion_code, i_front_cliff,
                    i_back_cliff, i_estop_latched));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            got.dir = {o_br_dir, o_bl_dir, o_fr_dir, o_fl_dir};
            got.pwm = {o_br_pwm, o_bl_pwm, o_fr_pwm, o_fl_pwm};
            got.mode = o_drive_mode;
            got.reason = o_block_reason;
            if (got.reason != RSN_NONE) blocked_out++;
            if (wheel_words_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected wheel word %h", $time, got);
            end else begin
                want = wheel_words_due.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.dir[i] !== want.dir[i] || got.pwm[i] !== want.pwm[i]) begin
                        err_count++;
                        $display("%0t: wheel %0d exp dir %0d pwm %0d got dir %0d pwm %0d",
                            $time, i, want.dir[i], want.pwm[i], got.dir[i], got.pwm[i]);
                    end
                end
                if (got.mode !== want.mode) begin
                    err_count++;
                    $display("%0t: drive_mode exp %0d got %0d", $time, want.mode, got.mode);
                end
                if (got.reason !== want.reason) begin
                    err_count++;
                    $display("%0t: block_reason exp %0d got %0d", $time,
                        want.reason, got.reason);
                end
            end
        end
    end

    // Randomly stall the output side
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (wheel_words_due.size() != 0 || i_in_valid)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words pending", wheel_words_due.size());
            $display("tb_mecanum_drive_command_mixer_unit NOT OK");
            $finish;
        end
    end

    // Write one register; called only with no command in flight
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SPEED:  speed_reg = data;
            CFG_LAYOUT: opp_reg = data[0];
            CFG_INVERT: invert_reg = data[3:0];
            default: ;
        endcase
    endtask

    // Wait for every due word, then let the pipe empty
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (wheel_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Present one command word and hold it until accepted
    task automatic send_cmd(input t_cmd_row r);
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        i_req_type <= r.req;
        i_fwd_cmd <= 16'(r.f);
        i_left_cmd <= 16'(r.l);
        i_turn_cmd <= 16'(r.c);
        i_motion_code <= r.m;
        i_front_cliff <= r.fc;
        i_back_cliff <= r.bc;
        i_estop_latched <= r.es;
        row_typed <= r.typed;
        row_reason <= r.reason;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic int pick_component();
        case ($urandom_range(5))
            0: return 0;
            1: return $urandom_range(80) - 40;
            2: return $urandom_range(2000) - 1000;
            3: return $urandom_range(1) ? 32767 : -32768;
            4: return $urandom_range(4000) - 2000;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // Random command, mostly unblocked, with cliff escape moves mixed in
    function automatic t_cmd_row random_cmd();
        t_cmd_row r;
        r.req = $urandom_range(99) < 35;
        r.f = pick_component();
        r.l = pick_component();
        r.c = pick_component();
        r.m = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
        r.fc = $urandom_range(99) < 15;
        r.bc = $urandom_range(99) < 15;
        r.es = $urandom_range(99) < 8;
        if (!r.req && (r.fc ^ r.bc) && $urandom_range(1)) begin
            r.l = 0;
            r.c = 0;
            r.f = (r.fc ? -1 : 1) * $urandom_range(1000, 35);
        end
        r.typed = 1'b0;
        r.reason = RSN_NONE;
        return r;
    endfunction

    // Directed commands: safety cases, deadband, extremes, every motion code
    t_cmd_row directed [] = '{
        '{REQ_TWIST, 500, 0, 0, MC_STOP, 0, 0, 1, 1, RSN_ESTOP},
        '{REQ_TWIST, 34, -34, 0, MC_STOP, 0, 0, 0, 1, RSN_NONE},
        '{REQ_TWIST, 500, 0, 0, MC_STOP, 1, 1, 0, 1, RSN_BOTH},
        '{REQ_TWIST, 500, 0, 0, MC_STOP, 1, 0, 0, 1, RSN_FRONT},
        '{REQ_TWIST, -500, 0, 0, MC_STOP, 1, 0, 0, 0, RSN_NONE},
        '{REQ_TWIST, -500, 100, 0, MC_STOP, 1, 0, 0, 1, RSN_FRONT},
        '{REQ_TWIST, 500, 0, 0, MC_STOP, 0, 1, 0, 0, RSN_NONE},
        '{REQ_TWIST, -500, 0, 0, MC_STOP, 0, 1, 0, 1, RSN_BACK},
        '{REQ_TWIST, 32767, -32768, -32768, MC_STOP, 0, 0, 0, 0, RSN_NONE},
        '{REQ_TWIST, -32768, 32767, 32767, MC_STOP, 0, 0, 0, 0, RSN_NONE},
        '{REQ_TWIST, 35, -35, 0, MC_STOP, 0, 0, 0, 0, RSN_NONE},
        '{REQ_TWIST, 1000, 1000, 1000, MC_STOP, 0, 0, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_STOP, 1, 1, 1, 1, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_FWD, 0, 0, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_BACK, 1, 0, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_STR_L, 0, 0, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_STR_R, 0, 0, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_ROT_L, 0, 0, 1, 1, RSN_ESTOP},
        '{1'b1, 0, 0, 0, MC_ROT_R, 0, 0, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_FWD_L, 0, 1, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_FWD_R, 1, 0, 0, 1, RSN_FRONT},
        '{1'b1, 0, 0, 0, MC_BACK_L, 0, 1, 0, 1, RSN_BACK},
        '{1'b1, 0, 0, 0, MC_BACK_R, 0, 0, 0, 0, RSN_NONE},
        '{1'b1, 0, 0, 0, 4'd15, 0, 0, 0, 1, RSN_NONE},
        '{1'b1, 0, 0, 0, MC_FWD, 1, 1, 0, 1, RSN_BOTH}
    };

    // Register settings per phase: speed, layout, inversion
    int phase_cfg [6][3] = '{
        '{255, 1, 15}, '{0, 0, 5}, '{1, 1, 10}, '{180, 0, 0}, '{255, 0, 15}, '{-1, -1, -1}
    };

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings
        foreach (directed[i]) send_cmd(directed[i]);
        drain_pipe();

        // Random phases across settings and flow-control patterns
        for (int p = 0; p < 6; p++) begin
            if (phase_cfg[p][0] < 0) begin
                write_reg(CFG_SPEED, 8'($urandom));
                write_reg(CFG_LAYOUT, 8'($urandom_range(1)));
                write_reg(CFG_INVERT, 8'($urandom_range(15)));
            end else begin
                write_reg(CFG_SPEED, 8'(phase_cfg[p][0]));
                write_reg(CFG_LAYOUT, 8'(phase_cfg[p][1]));
                write_reg(CFG_INVERT, 8'(phase_cfg[p][2]));
            end
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 45; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 45; end
                default: begin send_gap_pct = 6; stall_pct = 6; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) send_cmd(random_cmd());
            drain_pipe();
        end

        $display("commands sent %0d, wheel words checked %0d, %0d of them blocked",
            words_in, words_out, blocked_out);
        $display("six register settings, four flow-control patterns, %0d mismatches",
            err_count);
        if (err_count == 0)
            $display("tb_mecanum_drive_command_mixer_unit OK");
        else
            $display("tb_mecanum_drive_command_mixer_unit NOT OK");
        $finish;
    end

endmodule
